FILE: rtl/core/kmca_pkg.sv
// package for the k-way merge count aggregator
// holds sizes, item types and state encodings; no dependencies
package kmca_pkg;
   localparam int NUM_BANKS  = 16;
   localparam int LIST_DEPTH = 1024;
   localparam int KMER_BITS  = 62;
   localparam int BANK_W     = $clog2(NUM_BANKS);
   localparam int POS_W      = $clog2(LIST_DEPTH);
   localparam int LVL_W      = POS_W + 1;
   localparam int ADDR_W     = BANK_W + POS_W;
   localparam int KMER_W     = 62;
   localparam int CNT_W      = 32;
   localparam int FBANK_W    = 4;

   localparam logic [1:0] KIND_LOAD  = 2'd0;
   localparam logic [1:0] KIND_STEP  = 2'd1;
   localparam logic [1:0] KIND_CLEAR = 2'd2;

   typedef struct packed {
      logic [1:0]         kind;
      logic [FBANK_W-1:0] bank;
      logic [KMER_W-1:0]  kmer;
      logic [CNT_W-1:0]   abundance;
   } req_type;

   typedef struct packed {
      logic [KMER_W-1:0]  merged_kmer;
      logic [FBANK_W-1:0] out_bank;
      logic [CNT_W-1:0]   bank_total;
      logic               last;
      logic               done_res;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_SCAN_RD, ST_SCAN_CMP, ST_SCAN_NEXT, ST_DONE,
      ST_RUN_RD, ST_RUN_CHK, ST_EMIT
   } state_type;

   typedef struct packed {
      logic              wr_en;
      logic [ADDR_W-1:0] wr_addr;
      logic [ADDR_W-1:0] rd_addr;
   } mem_ctl_type;
endpackage

FILE: rtl/core/kmca_stream_if.sv
// valid/ready channel interface carrying one payload type
// no package dependencies; the payload type is a parameter
interface kmca_stream_if #(parameter type T = logic);
   logic valid;
   logic ready;
   T     data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/core/kway_merge_count_aggregator_unit.sv
// top level of the k-way merge count aggregator: sequencer, list pointers
// depends on kmca_pkg, kmca_stream_if and kmca_entry_mem
//
//  channel | direction | payload
//  req     | in        | kind, bank, kmer, abundance
//  rsp     | out       | merged_kmer, out_bank, bank_total, last, done_res
//
// load, clear and unused kinds are taken in idle; a step scans each bank head
// (read, compare, next) via the single memory read port, gives a done result
// if none, else reads each run entry (read, check) plus one stop check per bank,
// then walks the sums one bank a cycle unless stalled, to the last nonzero one
// reset is synchronous and clears list levels, pointers and sums
// results leave through an output register; a stall holds the sequencer and
// input stays blocked until the last result of a step has left
module kway_merge_count_aggregator_unit (
   input logic clock,
   input logic reset,
   kmca_stream_if.sink   req,
   kmca_stream_if.source rsp
);
   localparam int BW = kmca_pkg::BANK_W;
   localparam int PW = kmca_pkg::POS_W;
   localparam int LW = kmca_pkg::LVL_W;
   localparam int NB = kmca_pkg::NUM_BANKS;
   localparam logic [LW-1:0] DEPTH_L = LW'(kmca_pkg::LIST_DEPTH);
   localparam logic [kmca_pkg::KMER_W-1:0] KMASK =
      kmca_pkg::KMER_W'((65'd1 << kmca_pkg::KMER_BITS) - 65'd1);

   kmca_pkg::state_type state_ff, state_in;
   logic [LW-1:0] fill_ff [NB];
   logic [LW-1:0] pos_ff [NB];
   logic [kmca_pkg::CNT_W-1:0] sum_ff [NB];
   logic [BW-1:0] bank_ff, bank_in;
   logic [kmca_pkg::KMER_W-1:0] best_ff, best_in;
   logic found_ff, found_in;
   logic [BW-1:0] lastb_ff, lastb_in;
   logic any_ff, any_in;
   kmca_pkg::rsp_type out_ff, out_in;
   logic out_v_ff, out_v_in;
   kmca_pkg::mem_ctl_type ctl;
   logic [kmca_pkg::KMER_W-1:0] rd_kmer;
   logic [kmca_pkg::CNT_W-1:0] rd_count;
   logic has_head;
   logic [kmca_pkg::CNT_W:0] add;
   logic load_ok;

   kmca_entry_mem u_mem (.clock(clock), .ctl(ctl), .wr_kmer(req.data.kmer & KMASK),
      .wr_count(req.data.abundance), .rd_kmer(rd_kmer), .rd_count(rd_count));

   assign has_head = pos_ff[bank_ff] < fill_ff[bank_ff];
   assign add = {1'b0, sum_ff[bank_ff]} + {1'b0, rd_count};
   assign req.ready = (state_ff == kmca_pkg::ST_IDLE) && !out_v_ff;
   assign load_ok = req.valid && req.ready && req.data.kind == kmca_pkg::KIND_LOAD &&
      (32'(req.data.bank) < NB) && fill_ff[BW'(req.data.bank)] < DEPTH_L;
   assign rsp.valid = out_v_ff;
   assign rsp.data = out_ff;

   always_comb begin
      ctl.wr_en = load_ok;
      ctl.wr_addr = {BW'(req.data.bank), fill_ff[BW'(req.data.bank)][PW-1:0]};
      ctl.rd_addr = {bank_ff, pos_ff[bank_ff][PW-1:0]};
   end

   always_comb begin
      state_in = state_ff;
      bank_in = bank_ff;
      best_in = best_ff;
      found_in = found_ff;
      lastb_in = lastb_ff;
      any_in = any_ff;
      out_in = out_ff;
      out_v_in = out_v_ff && !rsp.ready;
      case (state_ff)
         kmca_pkg::ST_IDLE: begin
            if (req.valid && req.ready && req.data.kind == kmca_pkg::KIND_STEP) begin
               bank_in = '0;
               found_in = 1'b0;
               state_in = kmca_pkg::ST_SCAN_RD;
            end
         end
         kmca_pkg::ST_SCAN_RD: state_in = kmca_pkg::ST_SCAN_CMP;
         kmca_pkg::ST_SCAN_CMP: begin
            if (has_head && (!found_ff || rd_kmer < best_ff)) begin
               best_in = rd_kmer;
               found_in = 1'b1;
            end
            state_in = kmca_pkg::ST_SCAN_NEXT;
         end
         kmca_pkg::ST_SCAN_NEXT: begin
            bank_in = bank_ff + 1'b1;
            if (bank_ff == BW'(NB - 1)) begin
               bank_in = '0;
               any_in = 1'b0;
               state_in = found_ff ? kmca_pkg::ST_RUN_RD : kmca_pkg::ST_DONE;
            end else begin
               state_in = kmca_pkg::ST_SCAN_RD;
            end
         end
         kmca_pkg::ST_DONE: begin
            if (!out_v_ff || rsp.ready) begin
               out_in = '0;
               out_in.done_res = 1'b1;
               out_v_in = 1'b1;
               state_in = kmca_pkg::ST_IDLE;
            end
         end
         kmca_pkg::ST_RUN_RD: state_in = kmca_pkg::ST_RUN_CHK;
         kmca_pkg::ST_RUN_CHK: begin
            if (has_head && rd_kmer == best_ff) begin
               state_in = kmca_pkg::ST_RUN_RD;
            end else begin
               if (sum_ff[bank_ff] != '0) begin
                  lastb_in = bank_ff;
                  any_in = 1'b1;
               end
               bank_in = bank_ff + 1'b1;
               if (bank_ff == BW'(NB - 1)) begin
                  bank_in = '0;
                  state_in = kmca_pkg::ST_EMIT;
               end else begin
                  state_in = kmca_pkg::ST_RUN_RD;
               end
            end
         end
         kmca_pkg::ST_EMIT: begin
            if (!any_ff) begin
               state_in = kmca_pkg::ST_IDLE;
            end else if (!out_v_ff || rsp.ready) begin
               if (sum_ff[bank_ff] != '0) begin
                  out_in.merged_kmer = best_ff;
                  out_in.out_bank = kmca_pkg::FBANK_W'(bank_ff);
                  out_in.bank_total = sum_ff[bank_ff];
                  out_in.last = (bank_ff == lastb_ff);
                  out_in.done_res = 1'b0;
                  out_v_in = 1'b1;
               end
               bank_in = bank_ff + 1'b1;
               if (bank_ff == lastb_ff) state_in = kmca_pkg::ST_IDLE;
            end
         end
         default: state_in = kmca_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= kmca_pkg::ST_IDLE;
         out_v_ff <= 1'b0;
         bank_ff <= '0;
         found_ff <= 1'b0;
         any_ff <= 1'b0;
         for (int i = 0; i < NB; i++) begin
            fill_ff[i] <= '0;
            pos_ff[i] <= '0;
            sum_ff[i] <= '0;
         end
      end else begin
         state_ff <= state_in;
         out_v_ff <= out_v_in;
         bank_ff <= bank_in;
         found_ff <= found_in;
         any_ff <= any_in;
         if (load_ok) fill_ff[BW'(req.data.bank)] <= fill_ff[BW'(req.data.bank)] + 1'b1;
         if (req.valid && req.ready && req.data.kind == kmca_pkg::KIND_CLEAR) begin
            for (int i = 0; i < NB; i++) begin
               fill_ff[i] <= '0;
               pos_ff[i] <= '0;
               sum_ff[i] <= '0;
            end
         end
         if (req.valid && req.ready && req.data.kind == kmca_pkg::KIND_STEP) begin
            for (int i = 0; i < NB; i++) sum_ff[i] <= '0;
         end
         if (state_ff == kmca_pkg::ST_RUN_CHK && has_head && rd_kmer == best_ff) begin
            pos_ff[bank_ff] <= pos_ff[bank_ff] + 1'b1;
            sum_ff[bank_ff] <= add[kmca_pkg::CNT_W] ? '1 : add[kmca_pkg::CNT_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      best_ff <= best_in;
      lastb_ff <= lastb_in;
      out_ff <= out_in;
   end
endmodule

FILE: rtl/core/kmca_entry_mem.sv
// entry memory: k-mer and abundance per list slot, registered read port
// depends on kmca_pkg
module kmca_entry_mem (
   input  logic                           clock,
   input  kmca_pkg::mem_ctl_type          ctl,
   input  logic [kmca_pkg::KMER_W-1:0]    wr_kmer,
   input  logic [kmca_pkg::CNT_W-1:0]     wr_count,
   output logic [kmca_pkg::KMER_W-1:0]    rd_kmer,
   output logic [kmca_pkg::CNT_W-1:0]     rd_count
);
   localparam int DEPTH = kmca_pkg::NUM_BANKS * kmca_pkg::LIST_DEPTH;
   logic [kmca_pkg::KMER_W+kmca_pkg::CNT_W-1:0] mem [DEPTH];
   logic [kmca_pkg::KMER_W+kmca_pkg::CNT_W-1:0] rd_ff;

   always_ff @(posedge clock) begin
      if (ctl.wr_en) mem[ctl.wr_addr] <= {wr_kmer, wr_count};
      rd_ff <= mem[ctl.rd_addr];
   end
   assign rd_kmer  = rd_ff[kmca_pkg::KMER_W+kmca_pkg::CNT_W-1:kmca_pkg::CNT_W];
   assign rd_count = rd_ff[kmca_pkg::CNT_W-1:0];
endmodule

FILE: tb/kmca_tb_if.sv
// testbench package holding the directed stimulus row type
// depends on kmca_pkg
package kmca_tb_pkg;
   import kmca_pkg::*;
   typedef struct packed {
      req_type item;
      logic    check_fixed;
      rsp_type fixed_rsp;
   } stim_row_type;
endpackage

FILE: tb/tb.sv
// testbench for kway_merge_count_aggregator_unit: directed table, then random
// loads/steps/clears and unused kinds checked against a behavioral merge predictor
// depends on kmca_pkg, kmca_tb_pkg, kmca_stream_if and the rtl
module tb;
   import kmca_pkg::*;
   import kmca_tb_pkg::*;

   localparam int WATCHDOG_LIMIT = 200000;
   localparam logic [1:0] KIND_UNUSED = 2'd3;

   logic clock = 1'b0;
   logic reset = 1'b1;
   kmca_stream_if #(req_type) req ();
   kmca_stream_if #(rsp_type) rsp ();

   kway_merge_count_aggregator_unit u_dut (
      .clock(clock), .reset(reset), .req(req.sink), .rsp(rsp.source)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   logic [KMER_W-1:0] list_kmer [NUM_BANKS][LIST_DEPTH];
   logic [CNT_W-1:0]  list_count [NUM_BANKS][LIST_DEPTH];
   int unsigned       fill_cnt [NUM_BANKS];
   int unsigned       read_cnt [NUM_BANKS];
   rsp_type           expected_rsp_q [$];
   int                fixed_idx_q [$];
   int                error_count = 0;
   int                idle_cycles = 0;
   bit                quiet_mode = 0;
   bit                timed_out = 0;

   task automatic merge_predict(input req_type it);
      logic [KMER_W-1:0] best;
      logic [CNT_W:0]    acc;
      logic [CNT_W-1:0]  sums [NUM_BANKS];
      bit                found;
      int                n;
      rsp_type           r;
      found = 0;
      best = '0;
      n = 0;
      case (it.kind)
         KIND_LOAD: begin
            if (fill_cnt[it.bank] < LIST_DEPTH) begin
               list_kmer[it.bank][fill_cnt[it.bank]] = it.kmer;
               list_count[it.bank][fill_cnt[it.bank]] = it.abundance;
               fill_cnt[it.bank]++;
            end
         end
         KIND_CLEAR: begin
            for (int b = 0; b < NUM_BANKS; b++) begin
               fill_cnt[b] = 0;
               read_cnt[b] = 0;
            end
         end
         KIND_STEP: begin
            for (int b = 0; b < NUM_BANKS; b++) begin
               sums[b] = '0;
               if (read_cnt[b] < fill_cnt[b] &&
                   (!found || list_kmer[b][read_cnt[b]] < best)) begin
                  best = list_kmer[b][read_cnt[b]];
                  found = 1;
               end
            end
            if (!found) begin
               r = '0;
               r.done_res = 1'b1;
               expected_rsp_q.insert(expected_rsp_q.size(), r);
            end else begin
               for (int b = 0; b < NUM_BANKS; b++) begin
                  while (read_cnt[b] < fill_cnt[b] && list_kmer[b][read_cnt[b]] == best) begin
                     acc = sums[b] + list_count[b][read_cnt[b]];
                     sums[b] = acc[CNT_W] ? '1 : acc[CNT_W-1:0];
                     read_cnt[b]++;
                  end
               end
               for (int b = 0; b < NUM_BANKS; b++) begin
                  if (sums[b] != 0) begin
                     r = '0;
                     r.merged_kmer = best;
                     r.out_bank = b[FBANK_W-1:0];
                     r.bank_total = sums[b];
                     expected_rsp_q.insert(expected_rsp_q.size(), r);
                     n++;
                  end
               end
               if (n > 0) expected_rsp_q[$].last = 1'b1;
            end
         end
         default: ;
      endcase
   endtask

   task automatic send_item(input req_type it);
      bit idle_now;
      idle_now = !quiet_mode && ($urandom_range(99) < 33);
      while (idle_now) begin
         req.valid <= 1'b0;
         @(negedge clock);
         idle_now = $urandom_range(99) < 33;
      end
      req.valid <= 1'b1;
      req.data  <= it;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
      merge_predict(it);
      @(negedge clock);
   endtask

   function automatic req_type make_item(logic [1:0] kind, int bank,
                                         longint unsigned kmer, longint unsigned cnt);
      req_type it;
      it.kind = kind;
      it.bank = bank[FBANK_W-1:0];
      it.kmer = KMER_W'(kmer);
      it.abundance = CNT_W'(cnt);
      return it;
   endfunction

   always @(negedge clock) begin
      rsp.ready <= reset ? 1'b0 : (quiet_mode || $urandom_range(99) >= 33);
   end

   always @(posedge clock) begin
      if (!reset) begin
         if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
         if (rsp.valid && rsp.ready) begin
            if (expected_rsp_q.size() == 0) begin
               $display("%0t: unexpected transfer %p", $time, rsp.data);
               error_count++;
            end else begin
               if (rsp.data !== expected_rsp_q[0])
                  begin
                     $display("%0t: mismatch expected %p actual %p", $time,
                              expected_rsp_q[0], rsp.data);
                     error_count++;
                  end
               void'(expected_rsp_q.pop_front());
            end
         end
      end
   end

   task automatic run_merge_set(int banks_used, int per_bank);
      longint unsigned k;
      for (int b = 0; b < banks_used; b++) begin
         k = 64'($urandom_range(3));
         for (int i = 0; i < per_bank; i++) begin
            send_item(make_item(KIND_LOAD, $urandom_range(banks_used - 1), k,
                                64'(($urandom_range(9) == 0) ? 32'd0 :
                                ($urandom_range(9) == 0) ? 32'hFFFF_FFF0 + $urandom_range(15)
                                                         : $urandom_range(20))));
            if ($urandom_range(2) != 0) k = k + 64'($urandom_range(2));
         end
      end
   endtask

   initial begin
      stim_row_type rows [$];
      rsp_type      none_rsp;
      rsp_type      done_rsp;
      rsp_type      r;
      req_type      it;
      int           sent;
      int           nb;
      int           np;
      req.valid = 1'b0;
      req.data  = '0;
      rsp.ready = 1'b0;
      none_rsp = '0;
      done_rsp = '0;
      done_rsp.done_res = 1'b1;
      for (int b = 0; b < NUM_BANKS; b++) begin
         fill_cnt[b] = 0;
         read_cnt[b] = 0;
      end
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed table: fixed rows carry the result read off directly
      rows.insert(rows.size(), '{make_item(KIND_STEP, 0, 0, 0), 1'b1, done_rsp});
      rows.insert(rows.size(), '{make_item(KIND_UNUSED, 3, '1, '1), 1'b0, none_rsp});
      rows.insert(rows.size(), '{make_item(KIND_LOAD, 15, '1, '1), 1'b0, none_rsp});
      rows.insert(rows.size(), '{make_item(KIND_LOAD, 15, '1, 1), 1'b0, none_rsp});
      r = '0; r.merged_kmer = '1; r.out_bank = 4'd15; r.bank_total = '1; r.last = 1'b1;
      rows.insert(rows.size(), '{make_item(KIND_STEP, 0, 0, 0), 1'b1, r});
      rows.insert(rows.size(), '{make_item(KIND_STEP, 0, 0, 0), 1'b1, done_rsp});
      rows.insert(rows.size(), '{make_item(KIND_LOAD, 0, 0, 0), 1'b0, none_rsp});
      rows.insert(rows.size(), '{make_item(KIND_STEP, 0, 0, 0), 1'b0, none_rsp});
      rows.insert(rows.size(), '{make_item(KIND_LOAD, 3, 5, 7), 1'b0, none_rsp});
      rows.insert(rows.size(), '{make_item(KIND_LOAD, 3, 2, 1), 1'b0, none_rsp});
      rows.insert(rows.size(), '{make_item(KIND_LOAD, 9, 5, 4), 1'b0, none_rsp});
      rows.insert(rows.size(), '{make_item(KIND_LOAD, 0, 5, 64'hAAAA5555), 1'b0, none_rsp});
      rows.insert(rows.size(), '{make_item(KIND_STEP, 0, 0, 0), 1'b0, none_rsp});
      rows.insert(rows.size(), '{make_item(KIND_STEP, 0, 0, 0), 1'b0, none_rsp});
      rows.insert(rows.size(), '{make_item(KIND_CLEAR, 0, 0, 0), 1'b0, none_rsp});
      rows.insert(rows.size(), '{make_item(KIND_STEP, 0, 0, 0), 1'b1, done_rsp});
      for (int b = 0; b < NUM_BANKS; b++)
         rows.insert(rows.size(),
                     '{make_item(KIND_LOAD, b, 64'h1555_5555_5555_5555, 64'h5555AAAA),
                       1'b0, none_rsp});
      rows.insert(rows.size(), '{make_item(KIND_STEP, 0, 0, 0), 1'b0, none_rsp});
      foreach (rows[i]) begin
         send_item(rows[i].item);
         if (rows[i].check_fixed && expected_rsp_q.size() > 0 &&
             expected_rsp_q[$] !== rows[i].fixed_rsp) begin
            $display("%0t: table row %0d expected %p predicted %p", $time, i,
                     rows[i].fixed_rsp, expected_rsp_q[$]);
            error_count++;
         end
      end

      sent = rows.size();
      while (sent < 310) begin
         if ($urandom_range(9) == 0) quiet_mode = ~quiet_mode;
         case ($urandom_range(9))
            0: begin
               it = make_item(2'($urandom_range(3)), $urandom_range(15),
                              {$urandom, $urandom}, 64'($urandom));
               send_item(it);
               sent++;
            end
            1: begin
               send_item(make_item(KIND_CLEAR, 0, 0, 0));
               sent++;
            end
            2, 3, 4: begin
               nb = $urandom_range(2, 16);
               np = $urandom_range(1, 3);
               run_merge_set(nb, np);
               sent += nb * np;
            end
            default: begin
               send_item(make_item(KIND_STEP, $urandom_range(15), {$urandom, $urandom},
                                   64'($urandom)));
               sent++;
            end
         endcase
      end
      req.valid <= 1'b0;
      quiet_mode = 0;
      while (expected_rsp_q.size() != 0 && !timed_out) @(posedge clock);
      repeat (200) @(posedge clock);
      if (!timed_out) begin
         if (error_count == 0 && expected_rsp_q.size() == 0)
            $display("kway_merge_count_aggregator_unit test passed");
         else
            $display("kway_merge_count_aggregator_unit test failed");
         $finish;
      end
   end

   initial begin
      wait (idle_cycles >= WATCHDOG_LIMIT);
      timed_out = 1;
      $display("kway_merge_count_aggregator_unit test failed");
      $finish;
   end
endmodule
